// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned PadLimit = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_SCHED,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha_state_t;

  typedef logic [31:0] word_t;

  localparam word_t InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic load;     // copy hash words into the working variables
    logic round;    // run one round
    logic update;   // add working variables into the hash words
    logic reinit;   // reload initial hash values
  } rnd_ctrl_t;

endpackage

// ===== hw/rtl/sha_round.sv =====
module sha_round
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rnd_ctrl_t   ctrl,
  input  logic [5:0]  round_idx,
  input  word_t       sched_word,
  input  logic [2:0]  rd_idx,
  output word_t       hash_word
);

  word_t h_r [8];
  word_t v_r [8];
  word_t big0, big1, ch, maj, t1, t2;

  assign hash_word = h_r[rd_idx];

  always_comb begin
    big1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]} ^
           {v_r[4][24:0], v_r[4][31:25]};
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + round_const(round_idx) + sched_word;
    big0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]} ^
           {v_r[0][21:0], v_r[0][31:22]};
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= InitH[i];
        v_r[i] <= '0;
      end
    end else begin
      if (ctrl.load) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end else if (ctrl.round) begin
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (ctrl.reinit) begin
        for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
      end else if (ctrl.update) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

endmodule

// ===== hw/rtl/sha256_message_hasher.sv =====
// A byte that does not fill a block is taken while idle; a full block then
// runs a load, 64 rounds and a hash update, with the block buffer shifting
// as the schedule. An ending item adds one or two compressions and the pad
// bytes, then emits eight words, one per accepted cycle. No byte is taken
// while the single round unit compresses a block, nor while padding or emitting.
// Reset is synchronous, active low; it loads the initial hash values.
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_state_t state_r, state_nxt;
  word_t      w_r [16];
  logic [5:0] pos_r;
  logic [63:0] bits_r;
  logic [5:0] rnd_r;
  logic       fin_r;     // message ending: padding pending or in progress
  logic       lenok_r;   // the block being padded or compressed carries the length
  logic       pad_owed_r; // the 0x80 pad byte has not been placed yet
  logic [2:0] emit_r;
  rnd_ctrl_t  ctrl;
  word_t      s0, s1, new_w;
  logic       acc, last_rnd, out_fire, byte_full, lenok_now;
  logic [1:0] bsel;
  logic [4:0] shamt;
  logic [7:0] pad_byte;
  word_t      mask, wv;

  assign acc      = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign last_rnd = (rnd_r == 6'(NumRounds - 1));
  assign byte_full = in_byte_valid && (pos_r == 6'd63);

  // Message schedule computed in place over a 16-word window.
  always_comb begin
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^
         (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]} ^
         (w_r[14] >> 10);
    new_w = w_r[0] + s0 + w_r[9] + s1;
  end

  sha_round u_round (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .round_idx(rnd_r),
    .sched_word(w_r[0]), .rd_idx(emit_r), .hash_word(out_digest_word)
  );

  // The block that receives the pad byte carries the length when the pad
  // byte lands before byte 56.
  always_comb begin
    pad_byte  = pad_owed_r ? 8'h80 : 8'h00;
    lenok_now = pad_owed_r ? (pos_r < 6'(PadLimit)) : lenok_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (byte_full) state_nxt = ST_SCHED;
          else if (in_end_of_message) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos_r == 6'(PadLimit - 1) && lenok_now) state_nxt = ST_SCHED;
        else if (pos_r == 6'd63) state_nxt = ST_SCHED;
      end
      ST_SCHED: state_nxt = ST_ROUND;
      ST_ROUND: if (last_rnd) state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (lenok_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT: if (out_fire && emit_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    ctrl.load   = (state_r == ST_SCHED);
    ctrl.round  = (state_r == ST_ROUND);
    ctrl.update = (state_r == ST_UPDATE);
    ctrl.reinit = out_fire && (emit_r == 3'd7);
  end

  assign out_word_index = emit_r;
  assign out_last_word  = (emit_r == 3'd7);

  always_comb begin
    bsel  = pos_r[1:0];
    shamt = {2'd3 - bsel, 3'b000};
    mask  = 32'hFF << shamt;
    wv    = (bsel == 2'd0) ? '0 : (w_r[pos_r[5:2]] & ~mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      bits_r     <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      lenok_r    <= 1'b0;
      pad_owed_r <= 1'b0;
      emit_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            fin_r      <= in_end_of_message;
            pad_owed_r <= in_end_of_message;
            if (in_byte_valid) begin
              w_r[pos_r[5:2]] <= wv | ({24'd0, in_data_byte} << shamt);
              pos_r  <= pos_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
          end
        end
        ST_PAD: begin
          w_r[pos_r[5:2]] <= wv | ({24'd0, pad_byte} << shamt);
          pad_owed_r <= 1'b0;
          lenok_r    <= lenok_now;
          if (pos_r == 6'(PadLimit - 1) && lenok_now) begin
            w_r[14] <= bits_r[63:32];
            w_r[15] <= bits_r[31:0];
            pos_r   <= '0;
          end else begin
            pos_r <= pos_r + 6'd1;
          end
        end
        ST_SCHED: rnd_r <= '0;
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= new_w;
          rnd_r <= rnd_r + 6'd1;
        end
        ST_UPDATE: begin
          // A further block follows; it is the one that carries the length.
          if (fin_r && !lenok_r) lenok_r <= 1'b1;
        end
        ST_EMIT: begin
          if (out_fire) begin
            emit_r <= emit_r + 3'd1;
            if (emit_r == 3'd7) begin
              fin_r   <= 1'b0;
              lenok_r <= 1'b0;
              bits_r  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_round_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && !last_rnd) |=> rnd_r == $past(rnd_r) + 6'd1)
    else $error("round count skipped");
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last_word |=> out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest word order");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word) &&
    $stable(out_word_index)) else $error("digest item changed while waiting");
`endif

endmodule
